// ===== rtl/core/rvx_pkg.sv =====
// Shared definitions for the RV32I execute block: instruction codes, ALU codes,
// memory geometry and the structs passed between the submodules.
// No dependencies.
package rvx_pkg;

  // Data memory geometry. The byte count must be a power of two (16 to 65536);
  // it is split into four byte banks of DMEM_ROWS rows each.
  localparam int DMEM_BYTES = 4096;
  localparam int DMEM_AW    = $clog2(DMEM_BYTES);
  localparam int DMEM_ROWS  = DMEM_BYTES / 4;
  localparam int ROW_AW     = DMEM_AW - 2;

  // Decoded instruction codes.
  typedef logic [5:0] action_t;
  localparam action_t ACT_ADD    = 6'd0;
  localparam action_t ACT_AND    = 6'd9;
  localparam action_t ACT_ADDI   = 6'd10;
  localparam action_t ACT_SLLI   = 6'd11;
  localparam action_t ACT_SLTI   = 6'd12;
  localparam action_t ACT_SLTIU  = 6'd13;
  localparam action_t ACT_XORI   = 6'd14;
  localparam action_t ACT_SRLI   = 6'd15;
  localparam action_t ACT_SRAI   = 6'd16;
  localparam action_t ACT_ORI    = 6'd17;
  localparam action_t ACT_ANDI   = 6'd18;
  localparam action_t ACT_LB     = 6'd19;
  localparam action_t ACT_LH     = 6'd20;
  localparam action_t ACT_LW     = 6'd21;
  localparam action_t ACT_LBU    = 6'd22;
  localparam action_t ACT_LHU    = 6'd23;
  localparam action_t ACT_SB     = 6'd24;
  localparam action_t ACT_SH     = 6'd25;
  localparam action_t ACT_SW     = 6'd26;
  localparam action_t ACT_BEQ    = 6'd27;
  localparam action_t ACT_BNE    = 6'd28;
  localparam action_t ACT_BLT    = 6'd29;
  localparam action_t ACT_BGE    = 6'd30;
  localparam action_t ACT_BLTU   = 6'd31;
  localparam action_t ACT_BGEU   = 6'd32;
  localparam action_t ACT_JAL    = 6'd33;
  localparam action_t ACT_JALR   = 6'd34;
  localparam action_t ACT_LUI    = 6'd35;
  localparam action_t ACT_AUIPC  = 6'd36;
  localparam action_t ACT_ECALL  = 6'd37;
  localparam action_t ACT_EBREAK = 6'd38;

  // ALU operation codes; they match the register-form instruction codes.
  typedef logic [3:0] alu_op_t;
  localparam alu_op_t ALU_ADD  = 4'd0;
  localparam alu_op_t ALU_SUB  = 4'd1;
  localparam alu_op_t ALU_SLL  = 4'd2;
  localparam alu_op_t ALU_SLT  = 4'd3;
  localparam alu_op_t ALU_SLTU = 4'd4;
  localparam alu_op_t ALU_XOR  = 4'd5;
  localparam alu_op_t ALU_SRL  = 4'd6;
  localparam alu_op_t ALU_SRA  = 4'd7;
  localparam alu_op_t ALU_OR   = 4'd8;
  localparam alu_op_t ALU_AND  = 4'd9;

  // Memory access sizes.
  typedef logic [1:0] size_t;
  localparam size_t SIZE_B = 2'd0;
  localparam size_t SIZE_H = 2'd1;
  localparam size_t SIZE_W = 2'd2;

  // Data memory request for one instruction.
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [DMEM_AW-1:0] addr;
    size_t              size;
    logic [31:0]        wdata;
  } mem_req_t;

  // Register file write port.
  typedef struct packed {
    logic        we;
    logic [4:0]  idx;
    logic [31:0] val;
  } rf_wr_t;

  // Comparison flags for branches.
  typedef struct packed {
    logic eq;
    logic lt;
    logic ltu;
  } cmp_t;

  // ALU operation for an immediate-form instruction.
  function automatic alu_op_t imm_alu_op(action_t act);
    alu_op_t op;
    unique case (act)
      ACT_SLLI:  op = ALU_SLL;
      ACT_SLTI:  op = ALU_SLT;
      ACT_SLTIU: op = ALU_SLTU;
      ACT_XORI:  op = ALU_XOR;
      ACT_SRLI:  op = ALU_SRL;
      ACT_SRAI:  op = ALU_SRA;
      ACT_ORI:   op = ALU_OR;
      ACT_ANDI:  op = ALU_AND;
      default:   op = ALU_ADD;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/core/rvx_alu.sv =====
// Integer ALU and branch comparator of the RV32I execute block.
// Depends on rvx_pkg.
module rvx_alu import rvx_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] cmp_b,
  output logic [31:0] result,
  output cmp_t        cmp
);

  logic [4:0] shamt;
  logic       lt_s;
  logic       lt_u;

  // Shift amounts use only the low five bits.
  assign shamt = b[4:0];
  assign lt_s  = $signed(a) < $signed(b);
  assign lt_u  = a < b;

  // Arithmetic and logic result.
  always_comb begin
    unique case (op)
      ALU_ADD:  result = a + b;
      ALU_SUB:  result = a - b;
      ALU_SLL:  result = a << shamt;
      ALU_SLT:  result = {31'd0, lt_s};
      ALU_SLTU: result = {31'd0, lt_u};
      ALU_XOR:  result = a ^ b;
      ALU_SRL:  result = a >> shamt;
      ALU_SRA:  result = $unsigned($signed(a) >>> shamt);
      ALU_OR:   result = a | b;
      ALU_AND:  result = a & b;
      default:  result = a & b;
    endcase
  end

  // Branch flags always compare against the second register operand.
  assign cmp.eq  = a == cmp_b;
  assign cmp.lt  = $signed(a) < $signed(cmp_b);
  assign cmp.ltu = a < cmp_b;

endmodule

// ===== rtl/core/rvx_regfile.sv =====
// General register file: 32 words, two registered read ports with write bypass,
// one write port, and a valid bit per entry so that reset reads as zero.
// Depends on rvx_pkg.
module rvx_regfile import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rs1,
  input  logic [4:0]  rs2,
  input  rf_wr_t      wr,
  output logic [31:0] rd_a,
  output logic [31:0] rd_b
);

  logic [31:0] regs [32];
  logic [31:0] valid;

  // Entry storage. The write port never targets x0.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.idx] <= wr.val;
    end
  end

  // Valid bits: an entry not yet written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // Registered reads; a write at the same edge is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && wr.idx == rs1) begin
        rd_a <= wr.val;
      end else begin
        rd_a <= valid[rs1] ? regs[rs1] : '0;
      end
      if (wr.we && wr.idx == rs2) begin
        rd_b <= wr.val;
      end else begin
        rd_b <= valid[rs2] ? regs[rs2] : '0;
      end
    end
  end

endmodule

// ===== rtl/core/rvx_dmem.sv =====
// Byte-addressed little-endian data memory built from four byte banks, with
// unaligned and wrapping accesses, registered read data and a clearing pass.
// Depends on rvx_pkg.
module rvx_dmem import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  mem_req_t    req,
  output logic [31:0] rdata,
  output logic        busy
);

  logic [7:0]        mem [4][DMEM_ROWS];
  logic [7:0]        bank_q [4];
  logic [ROW_AW-1:0] row [4];
  logic [ROW_AW-1:0] base_row;
  logic [ROW_AW-1:0] clr_row;
  logic [1:0]        off;
  logic [1:0]        off_q;
  logic [3:0]        lane_mask;
  logic [7:0]        mask_wide;
  logic [3:0]        bank_en;
  logic [63:0]       wdata_wide;
  logic [31:0]       wdata_rot;
  logic [31:0]       rword;
  logic [63:0]       rword_wide;

  assign base_row = req.addr[DMEM_AW-1:2];
  assign off      = req.addr[1:0];

  // Banks below the start offset hold the bytes that spill into the next row.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      row[k] = base_row + ROW_AW'(2'(k) < off);
    end
  end

  // Byte lanes in use for the access size.
  always_comb begin
    unique case (req.size)
      SIZE_B:  lane_mask = 4'b0001;
      SIZE_H:  lane_mask = 4'b0011;
      default: lane_mask = 4'b1111;
    endcase
  end

  // Rotate lanes and store data onto the banks by the start offset.
  assign mask_wide  = {lane_mask, lane_mask} << off;
  assign bank_en    = mask_wide[7:4];
  assign wdata_wide = {req.wdata, req.wdata} << {off, 3'b000};
  assign wdata_rot  = wdata_wide[63:32];

  // Clearing pass over all rows after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_AW'(DMEM_ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Bank writes: zeros during the clearing pass, store bytes afterwards.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (busy) begin
        mem[k][clr_row] <= '0;
      end else if (step && req.wr && bank_en[k]) begin
        mem[k][row[k]] <= wdata_rot[8*k +: 8];
      end
    end
  end

  // Registered bank reads, held until the next load.
  always_ff @(posedge clk) begin
    if (step && req.rd) begin
      for (int k = 0; k < 4; k++) begin
        bank_q[k] <= mem[k][row[k]];
      end
      off_q <= off;
    end
  end

  // Rotate the bank bytes back into lane order.
  assign rword      = {bank_q[3], bank_q[2], bank_q[1], bank_q[0]};
  assign rword_wide = {rword, rword} >> {off_q, 3'b000};
  assign rdata      = rword_wide[31:0];

endmodule

// ===== rtl/core/rv32i_execute_step.sv =====
// Top level of the RV32I execute block: operand stage, memory/writeback stage
// and output register, with program counter and halt state.
// Depends on rvx_pkg, rvx_alu, rvx_regfile and rvx_dmem.
//
//   Channel  Direction  Handshake             Contents
//   in       into       in_valid / in_ready   action, dest_reg, src_reg_a/b, immediate
//   out      out of     out_valid / out_ready instr_pc, next_pc, reg_written,
//                                             written_index, written_value,
//                                             branch_taken, halt_flag
//   cfg      into       cfg_wr_en             cfg_wr_data (start_pc)
//
// One instruction is accepted per cycle while in_ready is high; its result passes
// through the operand stage, the memory/writeback stage and the output register.
// The load-to-use path is covered by forwarding, so dependent instructions
// still issue back to back.
// After reset the data memory is cleared one row per cycle over all DMEM_BYTES/4
// rows (1024 at 4096 bytes), and in_ready stays low until that pass ends.
// A stalled output holds the whole pipeline; apart from the clearing pass, in_ready
// drops only when every stage is full and the output transaction is not taken.
module rv32i_execute_step import rvx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         action,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src_reg_a,
  input  logic [4:0]         src_reg_b,
  input  logic signed [31:0] immediate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        instr_pc,
  output logic [31:0]        next_pc,
  output logic               reg_written,
  output logic [4:0]         written_index,
  output logic [31:0]        written_value,
  output logic               branch_taken,
  output logic               halt_flag
);

  // Architectural state and configuration.
  logic [31:0] start_pc;
  logic        pc_init;
  logic [31:0] pc;
  logic        halted;

  // Operand stage.
  logic        s1_v;
  action_t     s1_action;
  logic [4:0]  s1_rd;
  logic [4:0]  s1_rs1;
  logic [4:0]  s1_rs2;
  logic [31:0] s1_imm;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  alu_op_t     alu_op;
  logic        alu_use_imm;
  logic [31:0] alu_res;
  cmp_t        cmp;
  logic [31:0] pc_plus4;
  logic [31:0] pc_plus_imm;
  logic [31:0] a_plus_imm;
  logic        s1_we_raw;
  logic        s1_we;
  logic [31:0] s1_val;
  logic [31:0] s1_npc;
  logic        s1_taken;
  logic        s1_load;
  logic        s1_store;
  size_t       s1_size;
  logic        s1_halt_set;
  mem_req_t    mem_req;

  // Memory/writeback stage.
  logic        s2_v;
  action_t     s2_action;
  logic        s2_we;
  logic        s2_load;
  logic [4:0]  s2_rd;
  logic [31:0] s2_val;
  logic [31:0] s2_pc;
  logic [31:0] s2_npc;
  logic        s2_taken;
  logic        s2_halt;
  logic [31:0] mem_rdata;
  logic [31:0] load_val;
  logic [31:0] wb_val;
  rf_wr_t      rf_wr;
  logic        mem_busy;

  // Flow control.
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic in_take;
  logic s1_adv;
  logic s2_adv;

  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_v || out_free;
  assign s1_free  = !s1_v || s2_free;
  assign in_ready = s1_free && !mem_busy;
  assign in_take  = in_valid && in_ready;
  assign s1_adv   = s1_v && s2_free;
  assign s2_adv   = s2_v && out_free;

  // Start address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= '0;
    end else if (cfg_wr_en) begin
      start_pc <= cfg_wr_data;
    end
  end

  // The pc takes the start address as reset leaves it, in the first cycle after
  // reset; it then follows the executed instructions.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc_init <= 1'b1;
      halted  <= 1'b0;
    end else begin
      pc_init <= 1'b0;
      if (pc_init) begin
        pc <= start_pc;
      end else if (s1_adv) begin
        pc     <= s1_npc;
        halted <= halted || s1_halt_set;
      end
    end
  end

  // Operand stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_take) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  // Operand stage payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= action;
      s1_rd     <= dest_reg;
      s1_rs1    <= src_reg_a;
      s1_rs2    <= src_reg_b;
      s1_imm    <= $unsigned(immediate);
    end
  end

  rvx_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .rd_en (in_take),
    .rs1   (src_reg_a),
    .rs2   (src_reg_b),
    .wr    (rf_wr),
    .rd_a  (rf_a),
    .rd_b  (rf_b)
  );

  // Forward the result still waiting in the writeback stage.
  assign op_a = (s2_v && s2_we && s2_rd == s1_rs1) ? wb_val : rf_a;
  assign op_b = (s2_v && s2_we && s2_rd == s1_rs2) ? wb_val : rf_b;

  // ALU operation and second operand.
  always_comb begin
    alu_op      = ALU_ADD;
    alu_use_imm = 1'b0;
    if (s1_action <= ACT_AND) begin
      alu_op = alu_op_t'(s1_action[3:0]);
    end else if (s1_action <= ACT_ANDI) begin
      alu_op      = imm_alu_op(s1_action);
      alu_use_imm = 1'b1;
    end
  end

  rvx_alu u_alu (
    .op     (alu_op),
    .a      (op_a),
    .b      (alu_use_imm ? s1_imm : op_b),
    .cmp_b  (op_b),
    .result (alu_res),
    .cmp    (cmp)
  );

  assign pc_plus4    = pc + 32'd4;
  assign pc_plus_imm = pc + s1_imm;
  assign a_plus_imm  = op_a + s1_imm;

  // Instruction decode: result value, next pc, memory access and halt.
  always_comb begin
    s1_we_raw   = 1'b0;
    s1_val      = '0;
    s1_npc      = pc_plus4;
    s1_taken    = 1'b0;
    s1_load     = 1'b0;
    s1_store    = 1'b0;
    s1_size     = SIZE_W;
    s1_halt_set = 1'b0;
    unique case (s1_action)
      ACT_ADD, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, ACT_AND,
      ACT_ADDI, ACT_SLLI, ACT_SLTI, ACT_SLTIU, ACT_XORI, ACT_SRLI, ACT_SRAI,
      ACT_ORI, ACT_ANDI: begin
        s1_we_raw = 1'b1;
        s1_val    = alu_res;
      end
      ACT_LB, ACT_LBU: begin
        s1_we_raw = 1'b1;
        s1_load   = 1'b1;
        s1_size   = SIZE_B;
      end
      ACT_LH, ACT_LHU: begin
        s1_we_raw = 1'b1;
        s1_load   = 1'b1;
        s1_size   = SIZE_H;
      end
      ACT_LW: begin
        s1_we_raw = 1'b1;
        s1_load   = 1'b1;
      end
      ACT_SB: begin
        s1_store = 1'b1;
        s1_size  = SIZE_B;
      end
      ACT_SH: begin
        s1_store = 1'b1;
        s1_size  = SIZE_H;
      end
      ACT_SW: begin
        s1_store = 1'b1;
      end
      ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BGE, ACT_BLTU, ACT_BGEU: begin
        unique case (s1_action)
          ACT_BEQ:  s1_taken = cmp.eq;
          ACT_BNE:  s1_taken = !cmp.eq;
          ACT_BLT:  s1_taken = cmp.lt;
          ACT_BGE:  s1_taken = !cmp.lt;
          ACT_BLTU: s1_taken = cmp.ltu;
          default:  s1_taken = !cmp.ltu;
        endcase
        if (s1_taken) begin
          s1_npc = pc_plus_imm;
        end
      end
      ACT_JAL: begin
        s1_we_raw = 1'b1;
        s1_val    = pc_plus4;
        s1_taken  = 1'b1;
        s1_npc    = pc_plus_imm;
      end
      ACT_JALR: begin
        s1_we_raw = 1'b1;
        s1_val    = pc_plus4;
        s1_taken  = 1'b1;
        s1_npc    = {a_plus_imm[31:1], 1'b0};
      end
      ACT_LUI: begin
        s1_we_raw = 1'b1;
        s1_val    = s1_imm;
      end
      ACT_AUIPC: begin
        s1_we_raw = 1'b1;
        s1_val    = pc_plus_imm;
      end
      ACT_ECALL, ACT_EBREAK: begin
        s1_halt_set = 1'b1;
      end
      default: begin
        s1_halt_set = 1'b0;
      end
    endcase
  end

  // Writes to x0 are dropped.
  assign s1_we = s1_we_raw && (s1_rd != 5'd0);

  assign mem_req.rd    = s1_load;
  assign mem_req.wr    = s1_store;
  assign mem_req.addr  = a_plus_imm[DMEM_AW-1:0];
  assign mem_req.size  = s1_size;
  assign mem_req.wdata = op_b;

  rvx_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_adv),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  // Writeback stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_adv) begin
      s2_v <= 1'b1;
    end else if (s2_adv) begin
      s2_v <= 1'b0;
    end
  end

  // Writeback stage payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_action <= s1_action;
      s2_we     <= s1_we;
      s2_load   <= s1_load;
      s2_rd     <= s1_rd;
      s2_val    <= s1_val;
      s2_pc     <= pc;
      s2_npc    <= s1_npc;
      s2_taken  <= s1_taken;
      s2_halt   <= halted || s1_halt_set;
    end
  end

  // Load data extension.
  always_comb begin
    unique case (s2_action)
      ACT_LB:  load_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
      ACT_LH:  load_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
      ACT_LBU: load_val = {24'd0, mem_rdata[7:0]};
      ACT_LHU: load_val = {16'd0, mem_rdata[15:0]};
      default: load_val = mem_rdata;
    endcase
  end

  assign wb_val    = s2_load ? load_val : s2_val;
  assign rf_wr.we  = s2_adv && s2_we;
  assign rf_wr.idx = s2_rd;
  assign rf_wr.val = wb_val;

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output transaction payload.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      instr_pc      <= s2_pc;
      next_pc       <= s2_npc;
      reg_written   <= s2_we;
      written_index <= s2_we ? s2_rd : 5'd0;
      written_value <= s2_we ? wb_val : 32'd0;
      branch_taken  <= s2_taken;
      halt_flag     <= s2_halt;
    end
  end

endmodule
